@@ rtl/core/gbuffer_edge_pixel_classifier_assert.svh @@
// Assertion macros used by the checker file of the edge pixel classifier.
`ifndef GBUFFER_EDGE_PIXEL_CLASSIFIER_ASSERT_SVH
`define GBUFFER_EDGE_PIXEL_CLASSIFIER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define GEPC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define GEPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/gepc_pkg.sv @@
// Types, constants and codes shared by the edge pixel classifier.
package gepc_pkg;

  localparam int unsigned DistBits   = 32;
  localparam int unsigned NormalBits = 16;
  localparam int unsigned ProdW      = 2 * NormalBits;
  localparam int unsigned SumW       = ProdW + 2;
  localparam int unsigned RgbW       = 24;
  localparam int unsigned IdW        = 16;
  localparam int unsigned TagW       = 16;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 32;

  localparam logic [DistBits-1:0] DistAll1 = '1;
  localparam logic [IdW-1:0]      MissId   = '1;
  // cos(tolerance) = 0.91 in Q6.(2*(NormalBits-2)), rounded
  localparam logic signed [SumW-1:0] CosTol =
    SumW'(((64'd91 << (2 * (NormalBits - 2))) + 64'd50) / 64'd100);

  typedef enum logic [1:0] {
    ReqBelow = 2'd0,
    ReqLeft  = 2'd1,
    ReqPixel = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    OccNone   = 2'd0,
    OccEdges  = 2'd1,
    OccHits   = 2'd2,
    OccDither = 2'd3
  } occ_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDetectMask       = 3'd0,
    CfgDistanceThresh   = 3'd1,
    CfgForegroundRgb    = 3'd2,
    CfgBackgroundRgb    = 3'd3,
    CfgRegionColourMode = 3'd4,
    CfgOcclusionMode    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]                   req_type;
    logic                         is_hit;
    logic [14:0]                  region_code;
    logic [TagW-1:0]              region_tag;
    logic [DistBits-1:0]          hit_distance;
    logic signed [NormalBits-1:0] normal_x;
    logic signed [NormalBits-1:0] normal_y;
    logic signed [NormalBits-1:0] normal_z;
    logic [RgbW-1:0]              region_rgb;
    logic                         occluder_hit;
    logic [DistBits-1:0]          occluder_distance;
    logic                         dither_phase;
  } in_t;

  typedef struct packed {
    logic            write_pixel;
    logic            is_edge_pixel;
    logic [RgbW-1:0] pixel_rgb;
  } out_t;

  typedef struct packed {
    logic [3:0]      detect_mask;
    logic [31:0]     distance_threshold;
    logic [RgbW-1:0] foreground_rgb;
    logic [RgbW-1:0] background_rgb;
    logic            region_colour_mode;
    occ_mode_e       shade_mode;
  } cfg_t;

  typedef struct packed {
    logic                         hit;
    logic [IdW-1:0]               id;
    logic [TagW-1:0]              tag;
    logic [DistBits-1:0]          depth;
    logic signed [NormalBits-1:0] nx;
    logic signed [NormalBits-1:0] ny;
    logic signed [NormalBits-1:0] nz;
    logic [RgbW-1:0]              rgb;
  } smp_t;

  // pixel state between the product stage and the result stage
  typedef struct packed {
    logic                me_hit;
    logic [DistBits-1:0] me_dist;
    logic [RgbW-1:0]     me_rgb;
    logic                lf_hit;
    logic [DistBits-1:0] lf_dist;
    logic [RgbW-1:0]     lf_rgb;
    logic                bl_hit;
    logic [DistBits-1:0] bl_dist;
    logic [RgbW-1:0]     bl_rgb;
    logic                id_ne;
    logic                tag_ne;
    logic [ProdW-1:0]    prod_lx;
    logic [ProdW-1:0]    prod_ly;
    logic [ProdW-1:0]    prod_lz;
    logic [ProdW-1:0]    prod_bx;
    logic [ProdW-1:0]    prod_by;
    logic [ProdW-1:0]    prod_bz;
    logic [DistBits-1:0] diff_l;
    logic [DistBits-1:0] diff_b;
    logic                occ_hit;
    logic [DistBits-1:0] occ_dist;
    logic                phase;
  } mid_t;

endpackage

@@ rtl/core/gepc_edge_eval.sv @@
// Edge decision, occlusion, write flag and colour selection for one pixel.
module gepc_edge_eval
  import gepc_pkg::*;
(
  input  mid_t mid_i,
  input  cfg_t cfg_i,
  output out_t res_o
);

  typedef enum logic [1:0] {
    OcBlocked = 2'd0,
    OcLit     = 2'd1,
    OcOpen    = 2'd2
  } occ_val_e;

  logic signed [SumW-1:0] dot_l, dot_b;
  logic                   nrm_edge, dist_edge, edge_hit, edge_px;
  occ_val_e               oc;
  logic                   wr;
  logic [DistBits-1:0]    u_dist;
  logic [RgbW-1:0]        u_rgb, edge_rgb;

  assign dot_l = SumW'($signed(mid_i.prod_lx)) + SumW'($signed(mid_i.prod_ly))
               + SumW'($signed(mid_i.prod_lz));
  assign dot_b = SumW'($signed(mid_i.prod_bx)) + SumW'($signed(mid_i.prod_by))
               + SumW'($signed(mid_i.prod_bz));

  assign nrm_edge  = (dot_l < CosTol) || (dot_b < CosTol);
  assign dist_edge = (mid_i.diff_l > DistBits'(cfg_i.distance_threshold))
                  || (mid_i.diff_b > DistBits'(cfg_i.distance_threshold));

  assign edge_hit = (cfg_i.detect_mask[0] && mid_i.id_ne)
                 || (cfg_i.detect_mask[1] && mid_i.tag_ne)
                 || (cfg_i.detect_mask[2] && dist_edge)
                 || (cfg_i.detect_mask[3] && nrm_edge);

  assign edge_px = mid_i.me_hit ? edge_hit : (mid_i.lf_hit || mid_i.bl_hit);

  always_comb begin
    oc = OcLit;
    if (cfg_i.shade_mode != OccNone && (mid_i.me_hit || edge_px)) begin
      if (!mid_i.occ_hit) begin
        oc = OcOpen;
      end else if (mid_i.occ_dist < mid_i.me_dist) begin
        oc = OcBlocked;
      end
    end
  end

  always_comb begin
    case (cfg_i.shade_mode)
      OccEdges:  wr = edge_px && (oc != OcBlocked);
      OccHits:   wr = (mid_i.me_hit || edge_px) && (oc != OcBlocked);
      OccDither: begin
        if (edge_px && oc != OcBlocked) begin
          wr = 1'b1;
        end else if (mid_i.me_hit && oc != OcBlocked) begin
          wr = (oc == OcOpen) || (oc == OcLit && !mid_i.phase);
        end else begin
          wr = 1'b0;
        end
      end
      default:   wr = edge_px;
    endcase
  end

  // nearest of pixel, left and below; ties go to the neighbour
  always_comb begin
    if (mid_i.me_dist < mid_i.lf_dist) begin
      u_dist = mid_i.me_dist;
      u_rgb  = mid_i.me_rgb;
    end else begin
      u_dist = mid_i.lf_dist;
      u_rgb  = mid_i.lf_rgb;
    end
    if (!(u_dist < mid_i.bl_dist)) begin
      u_rgb = mid_i.bl_rgb;
    end
  end

  assign edge_rgb = cfg_i.region_colour_mode ? u_rgb : cfg_i.foreground_rgb;

  assign res_o.write_pixel   = wr;
  assign res_o.is_edge_pixel = edge_px;
  assign res_o.pixel_rgb     = edge_px ? edge_rgb : cfg_i.background_rgb;

endmodule

@@ rtl/core/gbuffer_edge_pixel_classifier.sv @@
// Top level of the G-buffer edge pixel classifier.
// Takes one sample transfer per clock. Below and left samples load the neighbour registers and
// give no result; a pixel sample gives one result and becomes the next left neighbour; request
// type 3 is dropped. Three register stages: input register, product register (neighbour update,
// six 16x16 normal products, distance differences) and result register; the sustained rate is one
// item per clock, held only by backpressure on the result side. Configuration writes are registered
// and act on pixels already in the pipeline.
module gbuffer_edge_pixel_classifier
  import gepc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_t                out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t cfg_q;

  in_t  s0_q;
  logic s0_valid_q, s0_valid_d;
  mid_t mid_q, mid_d;
  logic mid_valid_q, mid_valid_d;
  out_t out_q, res;
  logic out_valid_q, out_valid_d;

  smp_t lf_q, bl_q, me;
  logic is_pixel, a_adv, mid_can_load, mid_adv, out_free;
  logic [DistBits-1:0] occ_sat;

  function automatic logic [DistBits-1:0] sat_dist(input logic [DistBits-1:0] v);
    return (v == DistAll1) ? DistAll1 - DistBits'(1) : v;
  endfunction

  function automatic logic [DistBits-1:0] abs_diff(input logic [DistBits-1:0] a,
                                                   input logic [DistBits-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.detect_mask        <= 4'd13;
      cfg_q.distance_threshold <= 32'd131072;
      cfg_q.foreground_rgb     <= 24'hFFFFFF;
      cfg_q.background_rgb     <= '0;
      cfg_q.region_colour_mode <= 1'b0;
      cfg_q.shade_mode         <= OccNone;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDetectMask:       cfg_q.detect_mask        <= cfg_wdata_i[3:0];
        CfgDistanceThresh:   cfg_q.distance_threshold <= cfg_wdata_i;
        CfgForegroundRgb:    cfg_q.foreground_rgb     <= cfg_wdata_i[RgbW-1:0];
        CfgBackgroundRgb:    cfg_q.background_rgb     <= cfg_wdata_i[RgbW-1:0];
        CfgRegionColourMode: cfg_q.region_colour_mode <= cfg_wdata_i[0];
        CfgOcclusionMode:    cfg_q.shade_mode         <= occ_mode_e'(cfg_wdata_i[1:0]);
        default: ;
      endcase
    end
  end

  // flow control
  assign out_free     = !out_valid_q || out_ready_i;
  assign mid_adv      = mid_valid_q && out_free;
  assign mid_can_load = !mid_valid_q || mid_adv;
  assign is_pixel     = (s0_q.req_type == ReqPixel);
  assign a_adv        = s0_valid_q && (!is_pixel || mid_can_load);
  assign in_ready_o   = !s0_valid_q || a_adv;

  assign s0_valid_d  = in_ready_o ? in_valid_i : s0_valid_q;
  assign mid_valid_d = mid_can_load ? (a_adv && is_pixel) : mid_valid_q;
  assign out_valid_d = out_free ? mid_valid_q : out_valid_q;

  // sample decode
  always_comb begin
    if (s0_q.is_hit) begin
      me.hit   = 1'b1;
      me.id    = {1'b0, s0_q.region_code};
      me.tag   = s0_q.region_tag;
      me.depth = sat_dist(s0_q.hit_distance);
      me.nx    = s0_q.normal_x;
      me.ny    = s0_q.normal_y;
      me.nz    = s0_q.normal_z;
      me.rgb   = s0_q.region_rgb;
    end else begin
      me.hit   = 1'b0;
      me.id    = MissId;
      me.tag   = '0;
      me.depth = DistAll1;
      me.nx    = '0;
      me.ny    = '0;
      me.nz    = '0;
      me.rgb   = '0;
    end
  end

  assign occ_sat = sat_dist(s0_q.occluder_distance);

  always_comb begin
    mid_d.me_hit   = me.hit;
    mid_d.me_dist  = me.depth;
    mid_d.me_rgb   = me.rgb;
    mid_d.lf_hit   = lf_q.hit;
    mid_d.lf_dist  = lf_q.depth;
    mid_d.lf_rgb   = lf_q.rgb;
    mid_d.bl_hit   = bl_q.hit;
    mid_d.bl_dist  = bl_q.depth;
    mid_d.bl_rgb   = bl_q.rgb;
    mid_d.id_ne    = (me.id != lf_q.id) || (me.id != bl_q.id);
    mid_d.tag_ne   = (me.tag != lf_q.tag) || (me.tag != bl_q.tag);
    mid_d.prod_lx  = ProdW'(me.nx) * ProdW'(lf_q.nx);
    mid_d.prod_ly  = ProdW'(me.ny) * ProdW'(lf_q.ny);
    mid_d.prod_lz  = ProdW'(me.nz) * ProdW'(lf_q.nz);
    mid_d.prod_bx  = ProdW'(me.nx) * ProdW'(bl_q.nx);
    mid_d.prod_by  = ProdW'(me.ny) * ProdW'(bl_q.ny);
    mid_d.prod_bz  = ProdW'(me.nz) * ProdW'(bl_q.nz);
    mid_d.diff_l   = abs_diff(me.depth, lf_q.depth);
    mid_d.diff_b   = abs_diff(me.depth, bl_q.depth);
    mid_d.occ_hit  = s0_q.occluder_hit;
    mid_d.occ_dist = occ_sat;
    mid_d.phase    = s0_q.dither_phase;
  end

  gepc_edge_eval u_eval (
    .mid_i (mid_q),
    .cfg_i (cfg_q),
    .res_o (res)
  );

  // control and neighbour state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      mid_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      lf_q        <= '0;
      bl_q        <= '0;
    end else begin
      s0_valid_q  <= s0_valid_d;
      mid_valid_q <= mid_valid_d;
      out_valid_q <= out_valid_d;
      if (a_adv) begin
        if (s0_q.req_type == ReqBelow) begin
          bl_q <= me;
        end else if (s0_q.req_type == ReqLeft || is_pixel) begin
          lf_q <= me;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s0_q <= in_data_i;
    end
    if (a_adv && is_pixel) begin
      mid_q <= mid_d;
    end
    if (mid_adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/core/gepc_checker.sv @@
// Port-level checker for the edge pixel classifier, bound to the top level.
`include "gbuffer_edge_pixel_classifier_assert.svh"

module gepc_checker
  import gepc_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input in_t                 in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input out_t                out_data_o,
  input logic                cfg_we_i,
  input logic [CfgIdxW-1:0]  cfg_idx_i,
  input logic [CfgDataW-1:0] cfg_wdata_i
);

  logic      px_in, px_out;
  logic [1:0] pend_q, pend_d;
  occ_mode_e occ_q;

  assign px_in  = in_valid_i && in_ready_o && (in_data_i.req_type == ReqPixel);
  assign px_out = out_valid_o && out_ready_i;
  assign pend_d = pend_q + 2'(px_in) - 2'(px_out);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      occ_q  <= OccNone;
    end else begin
      pend_q <= pend_d;
      if (cfg_we_i && cfg_idx_i == CfgOcclusionMode) begin
        occ_q <= occ_mode_e'(cfg_wdata_i[1:0]);
      end
    end
  end

  `GEPC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                    out_valid_o && $stable(out_data_o), "result changed while stalled")
  `GEPC_ASSERT_IMPL(a_no_spurious, out_valid_o, pend_q != 2'd0,
                    "result offered without a pending pixel")
  `GEPC_ASSERT_IMPL(a_capacity, px_in && !px_out, pend_q != 2'd3,
                    "more pixels in flight than pipeline stages")
  `GEPC_ASSERT_IMPL(a_write_plain, out_valid_o && occ_q == OccNone,
                    out_data_o.write_pixel == out_data_o.is_edge_pixel,
                    "write flag differs from edge flag without occlusion")

endmodule

bind gbuffer_edge_pixel_classifier gepc_checker u_checker (.*);
